// ===== sv/mbep_pkg.sv =====
// Shared types, constants and fixed-point helpers for the Mandelbrot escape pixel core.
package mbep_pkg;

    localparam int COORD_BITS  = 12;
    localparam int FIXED_WIDTH = 32;
    localparam int FRAC_BITS   = 28;
    localparam int ITER_BITS   = 16;
    localparam int COLOR_BITS  = 8;
    localparam int SQ_BITS     = 2 * FIXED_WIDTH - 1 - FRAC_BITS;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_START_RE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_RE  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_IM = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_IM  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ITER = 3'd4;

    localparam logic signed [FIXED_WIDTH-1:0] START_RE_RST = -32'sd400778588;
    localparam logic signed [FIXED_WIDTH-1:0] STEP_RE_RST  = 32'sd165701;
    localparam logic signed [FIXED_WIDTH-1:0] START_IM_RST = -32'sd22297569;
    localparam logic signed [FIXED_WIDTH-1:0] STEP_IM_RST  = 32'sd93207;
    localparam logic [ITER_BITS-1:0]          MAX_ITER_RST = 16'd1000;

    localparam logic [SQ_BITS:0] ESCAPE_LIMIT = (SQ_BITS+1)'(4) << FRAC_BITS;

    localparam logic [COLOR_BITS-1:0] RED_BASE   = 8'd29;
    localparam logic [COLOR_BITS-1:0] GREEN_BASE = 8'd24;
    localparam logic [COLOR_BITS-1:0] BLUE_BASE  = 8'd4;
    localparam logic [COLOR_BITS-1:0] GREEN_OFS  = 8'd64;
    localparam logic [COLOR_BITS-1:0] BLUE_OFS   = 8'd128;
    localparam logic [COLOR_BITS-1:0] RAMP_SPAN  = 8'd64;
    localparam logic [COLOR_BITS-1:0] RAMP_TOP   = 8'd192;
    localparam logic [COLOR_BITS-1:0] RAMP_GAIN  = 8'd3;

    typedef struct packed {
        logic [COORD_BITS-1:0] column;
        logic [COORD_BITS-1:0] row;
    } pixel_t;

    typedef struct packed {
        logic [ITER_BITS-1:0]  iteration_count;
        logic                  inside_res;
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
    } result_t;

    // saturate a 64-bit signed value to the fixed-point range
    function automatic logic signed [FIXED_WIDTH-1:0] sat_fx(input logic signed [63:0] v);
        logic signed [FIXED_WIDTH-1:0] res;
        if ((&v[63:FIXED_WIDTH-1]) || !(|v[63:FIXED_WIDTH-1]))
        begin
            res = v[FIXED_WIDTH-1:0];
        end
        else if (v[63])
        begin
            res = {1'b1, {(FIXED_WIDTH-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(FIXED_WIDTH-1){1'b1}}};
        end
        return res;
    endfunction

    function automatic logic signed [FIXED_WIDTH-1:0] add_fx(
        input logic signed [FIXED_WIDTH-1:0] a,
        input logic signed [FIXED_WIDTH-1:0] b
    );
        logic signed [FIXED_WIDTH:0]   s;
        logic signed [FIXED_WIDTH-1:0] res;
        s = {a[FIXED_WIDTH-1], a} + {b[FIXED_WIDTH-1], b};
        if (s[FIXED_WIDTH] == s[FIXED_WIDTH-1])
        begin
            res = s[FIXED_WIDTH-1:0];
        end
        else if (s[FIXED_WIDTH])
        begin
            res = {1'b1, {(FIXED_WIDTH-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(FIXED_WIDTH-1){1'b1}}};
        end
        return res;
    endfunction

    // 3 * clamp(idx - ofs, 0, 64)
    function automatic logic [COLOR_BITS-1:0] color_ramp(
        input logic [COLOR_BITS-1:0] idx,
        input logic [COLOR_BITS-1:0] ofs
    );
        logic [COLOR_BITS-1:0] d;
        logic [COLOR_BITS-1:0] res;
        d = idx - ofs;
        if (idx < ofs)
        begin
            res = '0;
        end
        else if (d >= RAMP_SPAN)
        begin
            res = RAMP_TOP;
        end
        else
        begin
            res = COLOR_BITS'(d * RAMP_GAIN);
        end
        return res;
    endfunction

endpackage

// ===== sv/mandelbrot_escape_pixel_core.sv =====
// Mandelbrot escape-time pixel core: one shared multiplier under a sequencer.
//
// Each pixel transaction forms c from the row (real part) and column (imaginary part)
// using the start/step registers, then iterates z = z*z + c in signed Q4.28 with
// saturation until |z|^2 reaches 4 or the count hits max_iterations. A single
// registered 32x32 multiplier does all the work, so each iteration steps through
// z_re^2, z_im^2, z_re*z_im and the update. A pixel that escapes also passes through
// the 8-step palette-index divider and the color lookup. pixel_stall is high from
// acceptance until the result is loaded into the output register; a new pixel can
// be taken while that result still waits. Configuration is to be written only while
// idle; the core itself does not enforce this.
module mandelbrot_escape_pixel_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write_en,
    input  logic [mbep_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [mbep_pkg::FIXED_WIDTH-1:0]       cfg_data,
    input  logic                                   pixel_valid,
    output logic                                   pixel_stall,
    input  mbep_pkg::pixel_t                       pixel,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output mbep_pkg::result_t                      result
);

    localparam int FW = mbep_pkg::FIXED_WIDTH;
    localparam int FB = mbep_pkg::FRAC_BITS;
    localparam int SQ = mbep_pkg::SQ_BITS;
    localparam int IB = mbep_pkg::ITER_BITS;
    localparam int CB = mbep_pkg::COLOR_BITS;
    localparam int NUM_BITS = IB + CB;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CRE,
        ST_CIM,
        ST_CIM_WR,
        ST_LOOP,
        ST_SQY,
        ST_CROSS,
        ST_UPDATE,
        ST_DIV,
        ST_PAL,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    logic signed [FW-1:0] start_re_reg, step_re_reg, start_im_reg, step_im_reg;
    logic [IB-1:0]        max_iter_reg;

    mbep_pkg::pixel_t     pix_reg, pix_next;
    logic signed [FW-1:0] mul_a, mul_b;
    logic signed [63:0]   prod_reg;
    logic signed [FW-1:0] c_re_reg, c_re_next, c_im_reg, c_im_next;
    logic signed [FW-1:0] zx_reg, zx_next, zy_reg, zy_next;
    logic [SQ-1:0]        sx_reg, sx_next;
    logic [SQ-1:0]        sy_cur;
    logic [IB-1:0]        count_reg, count_next;
    logic                 inside_reg, inside_next;
    logic [IB-1:0]        rem_reg, rem_next;
    logic [CB-1:0]        num_lo_reg, num_lo_next;
    logic [CB-1:0]        quot_reg, quot_next;
    logic [2:0]           bit_cnt_reg, bit_cnt_next;
    logic [CB-1:0]        red_reg, red_next, green_reg, green_next, blue_reg, blue_next;
    mbep_pkg::result_t    result_reg, result_next;

    logic [NUM_BITS-1:0]  num_full;
    logic [IB:0]          trial;
    logic                 trial_ok;
    logic                 escaped;
    logic                 out_free;

    assign pixel_stall  = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = result_reg;
    assign out_free     = !out_valid_reg || !result_stall;

    assign sy_cur   = prod_reg[SQ+FB-1:FB];
    assign escaped  = ({1'b0, sx_reg} + {1'b0, sy_cur}) >= mbep_pkg::ESCAPE_LIMIT;
    assign num_full = {count_reg, {CB{1'b0}}} - NUM_BITS'(count_reg);
    assign trial    = {rem_reg, num_lo_reg[CB-1]};
    assign trial_ok = trial >= {1'b0, max_iter_reg};

    always_comb
    begin
        case (state_reg)
            ST_CRE:
            begin
                mul_a = FW'({1'b0, pix_reg.row});
                mul_b = step_re_reg;
            end
            ST_CIM:
            begin
                mul_a = FW'({1'b0, pix_reg.column});
                mul_b = step_im_reg;
            end
            ST_LOOP:
            begin
                mul_a = zx_reg;
                mul_b = zx_reg;
            end
            ST_SQY:
            begin
                mul_a = zy_reg;
                mul_b = zy_reg;
            end
            default:
            begin
                mul_a = zx_reg;
                mul_b = zy_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        pix_next       = pix_reg;
        c_re_next      = c_re_reg;
        c_im_next      = c_im_reg;
        zx_next        = zx_reg;
        zy_next        = zy_reg;
        sx_next        = sx_reg;
        count_next     = count_reg;
        inside_next    = inside_reg;
        rem_next       = rem_reg;
        num_lo_next    = num_lo_reg;
        quot_next      = quot_reg;
        bit_cnt_next   = bit_cnt_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        result_next    = result_reg;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (pixel_valid)
                begin
                    pix_next   = pixel;
                    state_next = ST_CRE;
                end
            end
            ST_CRE:
            begin
                state_next = ST_CIM;
            end
            ST_CIM:
            begin
                c_re_next  = mbep_pkg::sat_fx({{(64-FW){start_re_reg[FW-1]}}, start_re_reg}
                                              + prod_reg);
                state_next = ST_CIM_WR;
            end
            ST_CIM_WR:
            begin
                c_im_next  = mbep_pkg::sat_fx({{(64-FW){start_im_reg[FW-1]}}, start_im_reg}
                                              + prod_reg);
                zx_next    = '0;
                zy_next    = '0;
                count_next = '0;
                state_next = ST_LOOP;
            end
            ST_LOOP:
            begin
                if (count_reg >= max_iter_reg)
                begin
                    inside_next = 1'b1;
                    red_next    = '0;
                    green_next  = '0;
                    blue_next   = '0;
                    state_next  = ST_OUT;
                end
                else
                begin
                    state_next = ST_SQY;
                end
            end
            ST_SQY:
            begin
                sx_next    = prod_reg[SQ+FB-1:FB];
                state_next = ST_CROSS;
            end
            ST_CROSS:
            begin
                if (escaped)
                begin
                    inside_next  = 1'b0;
                    rem_next     = num_full[NUM_BITS-1:CB];
                    num_lo_next  = num_full[CB-1:0];
                    bit_cnt_next = '0;
                    state_next   = ST_DIV;
                end
                else
                begin
                    zx_next = mbep_pkg::add_fx(
                        mbep_pkg::sat_fx(64'($signed({1'b0, sx_reg}) - $signed({1'b0, sy_cur}))),
                        c_re_reg);
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                zy_next    = mbep_pkg::add_fx(mbep_pkg::sat_fx(prod_reg >>> (FB - 1)), c_im_reg);
                count_next = count_reg + 1'b1;
                state_next = ST_LOOP;
            end
            ST_DIV:
            begin
                if (trial_ok)
                begin
                    rem_next = IB'(trial - {1'b0, max_iter_reg});
                end
                else
                begin
                    rem_next = trial[IB-1:0];
                end
                quot_next    = {quot_reg[CB-2:0], trial_ok};
                num_lo_next  = {num_lo_reg[CB-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (&bit_cnt_reg)
                begin
                    state_next = ST_PAL;
                end
            end
            ST_PAL:
            begin
                red_next   = mbep_pkg::RED_BASE + mbep_pkg::color_ramp(quot_reg, '0);
                green_next = mbep_pkg::GREEN_BASE
                             + mbep_pkg::color_ramp(quot_reg, mbep_pkg::GREEN_OFS);
                blue_next  = mbep_pkg::BLUE_BASE
                             + mbep_pkg::color_ramp(quot_reg, mbep_pkg::BLUE_OFS);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    result_next.iteration_count = count_reg;
                    result_next.inside_res      = inside_reg;
                    result_next.red             = red_reg;
                    result_next.green           = green_reg;
                    result_next.blue            = blue_reg;
                    out_valid_next              = 1'b1;
                    state_next                  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
            start_re_reg  <= mbep_pkg::START_RE_RST;
            step_re_reg   <= mbep_pkg::STEP_RE_RST;
            start_im_reg  <= mbep_pkg::START_IM_RST;
            step_im_reg   <= mbep_pkg::STEP_IM_RST;
            max_iter_reg  <= mbep_pkg::MAX_ITER_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            result_reg    <= result_next;
            if (cfg_write_en)
            begin
                case (cfg_index)
                    mbep_pkg::CFG_START_RE: start_re_reg <= cfg_data;
                    mbep_pkg::CFG_STEP_RE:  step_re_reg  <= cfg_data;
                    mbep_pkg::CFG_START_IM: start_im_reg <= cfg_data;
                    mbep_pkg::CFG_STEP_IM:  step_im_reg  <= cfg_data;
                    mbep_pkg::CFG_MAX_ITER: max_iter_reg <= cfg_data[IB-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= mul_a * mul_b;
        pix_reg     <= pix_next;
        c_re_reg    <= c_re_next;
        c_im_reg    <= c_im_next;
        zx_reg      <= zx_next;
        zy_reg      <= zy_next;
        sx_reg      <= sx_next;
        count_reg   <= count_next;
        inside_reg  <= inside_next;
        rem_reg     <= rem_next;
        num_lo_reg  <= num_lo_next;
        quot_reg    <= quot_next;
        bit_cnt_reg <= bit_cnt_next;
        red_reg     <= red_next;
        green_reg   <= green_next;
        blue_reg    <= blue_next;
    end

    a_valid_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == ST_OUT))
        else $error("result_valid rose outside the output state");

    a_inside_black: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.inside_res) |->
            (result.red == '0 && result.green == '0 && result.blue == '0))
        else $error("inside pixel is not black");

    a_inside_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.inside_res == (result.iteration_count >= max_iter_reg)))
        else $error("inside flag does not match the iteration count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.iteration_count <= max_iter_reg))
        else $error("iteration count beyond the limit");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the Mandelbrot escape-time pixel core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CFG_IDX_BITS = mbep_pkg::CFG_IDX_BITS;
    localparam int FIXED_WIDTH  = mbep_pkg::FIXED_WIDTH;
    localparam int FRAC_BITS    = mbep_pkg::FRAC_BITS;
    localparam int ITER_BITS    = mbep_pkg::ITER_BITS;
    localparam int COLOR_BITS   = mbep_pkg::COLOR_BITS;
    localparam int COORD_BITS   = mbep_pkg::COORD_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED_LO = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED_HI = 3'd7;

    localparam logic [FIXED_WIDTH-1:0] FX_MAX          = 32'h7FFF_FFFF;
    localparam logic [FIXED_WIDTH-1:0] FX_MIN          = 32'h8000_0000;
    localparam logic [FIXED_WIDTH-1:0] FX_NEG_TWO      = 32'hE000_0000;
    localparam logic [FIXED_WIDTH-1:0] FX_NEG_ONE_HALF = 32'hE800_0000;
    localparam logic [FIXED_WIDTH-1:0] FX_PITCH        = 32'd196608;

    localparam longint Q_HI = 64'sd2147483647;
    localparam longint Q_LO = -64'sd2147483648;

    localparam int RANDOM_PIXELS = 600;

    typedef struct {
        bit                       is_cfg;
        logic [CFG_IDX_BITS-1:0]  idx;
        logic [FIXED_WIDTH-1:0]   data;
        mbep_pkg::pixel_t         px;
        bit                       typed;
        mbep_pkg::result_t        want;
    } plan_row_t;

    logic                     clk;
    logic                     rst_n        = 1'b0;
    logic                     cfg_write_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index    = '0;
    logic [FIXED_WIDTH-1:0]   cfg_data     = '0;
    logic                     pixel_valid  = 1'b0;
    logic                     pixel_stall;
    mbep_pkg::pixel_t         pixel        = '0;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    mbep_pkg::result_t        result;

    // shadow of the register file
    longint      re0        = -400778588;
    longint      re_step    = 165701;
    longint      im0        = -22297569;
    longint      im_step    = 93207;
    int unsigned iter_limit = 1000;

    mbep_pkg::result_t pixel_results_due[$];
    plan_row_t         plan[$];

    bit          valid_q;
    bit          calm;
    int          stall_left;
    int          errors;
    int          results_seen;
    int          inside_seen;
    int          cfg_writes;

    mandelbrot_escape_pixel_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic longint sat_q(longint v);
        if (v > Q_HI)
        begin
            return Q_HI;
        end
        if (v < Q_LO)
        begin
            return Q_LO;
        end
        return v;
    endfunction

    function automatic logic [COLOR_BITS-1:0] ramp3(int v);
        if (v < 0)
        begin
            v = 0;
        end
        if (v > 64)
        begin
            v = 64;
        end
        return COLOR_BITS'(3 * v);
    endfunction

    function automatic mbep_pkg::result_t escape_pixel(mbep_pkg::pixel_t p);
        longint            c_re;
        longint            c_im;
        longint            zx;
        longint            zy;
        longint            sx;
        longint            sy;
        longint            nx;
        int unsigned       n;
        int                pal;
        mbep_pkg::result_t r;
        c_re = sat_q(re0 + longint'(p.row) * re_step);
        c_im = sat_q(im0 + longint'(p.column) * im_step);
        zx = 0;
        zy = 0;
        n = 0;
        while (n < iter_limit)
        begin
            sx = (zx * zx) >>> FRAC_BITS;
            sy = (zy * zy) >>> FRAC_BITS;
            if (sx + sy >= (longint'(4) <<< FRAC_BITS))
            begin
                break;
            end
            nx = sat_q(sat_q(sx - sy) + c_re);
            zy = sat_q(sat_q((zx * zy) >>> (FRAC_BITS - 1)) + c_im);
            zx = nx;
            n++;
        end
        r = '0;
        r.iteration_count = ITER_BITS'(n);
        r.inside_res = (n >= iter_limit);
        if (!r.inside_res)
        begin
            pal = int'((n * 255) / iter_limit);
            r.red   = 8'd29 + ramp3(pal);
            r.green = 8'd24 + ramp3(pal - 64);
            r.blue  = 8'd4 + ramp3(pal - 128);
        end
        return r;
    endfunction

    function automatic plan_row_t cfg_row(logic [CFG_IDX_BITS-1:0] idx,
                                          logic [FIXED_WIDTH-1:0] data);
        plan_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.data = data;
        return row;
    endfunction

    function automatic plan_row_t pix_row(int col, int rw);
        plan_row_t row;
        row = '{default: '0};
        row.px.column = COORD_BITS'(col);
        row.px.row = COORD_BITS'(rw);
        return row;
    endfunction

    function automatic plan_row_t chk_row(int col, int rw, int cnt, bit ins,
                                          int r, int g, int b);
        plan_row_t row;
        row = pix_row(col, rw);
        row.typed = 1'b1;
        row.want.iteration_count = ITER_BITS'(cnt);
        row.want.inside_res = ins;
        row.want.red = COLOR_BITS'(r);
        row.want.green = COLOR_BITS'(g);
        row.want.blue = COLOR_BITS'(b);
        return row;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (calm || roll < 65)
        begin
            return 0;
        end
        if (roll < 94)
        begin
            return $urandom_range(4, 1);
        end
        return $urandom_range(150, 20);
    endfunction

    function automatic logic [FIXED_WIDTH-1:0] jitter(int unsigned mag);
        int v;
        v = int'($urandom_range(mag));
        if ($urandom_range(1))
        begin
            v = -v;
        end
        return FIXED_WIDTH'(v);
    endfunction

    function automatic logic [FIXED_WIDTH-1:0] pick_extreme();
        case ($urandom_range(4))
            0: return FX_MAX;
            1: return FX_MIN;
            2: return '0;
            3: return 32'd1;
            default: return '1;
        endcase
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic take_result();
        mbep_pkg::result_t want;
        if (pixel_results_due.size() == 0)
        begin
            $display("%0t ns: result %h with no transaction outstanding", $time, result);
            errors++;
        end
        else
        begin
            want = pixel_results_due.pop_front();
            check_field("iteration_count", want.iteration_count, result.iteration_count);
            check_field("inside_res", want.inside_res, result.inside_res);
            check_field("red", want.red, result.red);
            check_field("green", want.green, result.green);
            check_field("blue", want.blue, result.blue);
            results_seen++;
            if (want.inside_res)
            begin
                inside_seen++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            take_result();
        end
        if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            result_stall <= 1'b0;
            stall_left = pick_gap();
        end
    end

    task automatic drop_valid();
        if (valid_q)
        begin
            pixel_valid <= 1'b0;
            valid_q = 1'b0;
        end
    endtask

    task automatic send_pixel(mbep_pkg::pixel_t p, mbep_pkg::result_t want);
        pixel_valid <= 1'b1;
        valid_q = 1'b1;
        pixel <= p;
        @(posedge clk);
        while (pixel_stall)
        begin
            @(posedge clk);
        end
        pixel_results_due.push_back(want);
    endtask

    task automatic sender_gap();
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            drop_valid();
            repeat (g) @(posedge clk);
        end
    endtask

    // wait for every outstanding transaction, then let the core go idle
    task automatic settle();
        drop_valid();
        while (pixel_results_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);
    endtask

    task automatic cfg_put(logic [CFG_IDX_BITS-1:0] idx,
                           logic [FIXED_WIDTH-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            mbep_pkg::CFG_START_RE: re0 = longint'($signed(data));
            mbep_pkg::CFG_STEP_RE:  re_step = longint'($signed(data));
            mbep_pkg::CFG_START_IM: im0 = longint'($signed(data));
            mbep_pkg::CFG_STEP_IM:  im_step = longint'($signed(data));
            mbep_pkg::CFG_MAX_ITER: iter_limit = data[ITER_BITS-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic new_scene(output int items);
        int                      roll;
        int unsigned             lim;
        logic [FIXED_WIDTH-1:0]  sr;
        logic [FIXED_WIDTH-1:0]  dr;
        logic [FIXED_WIDTH-1:0]  si;
        logic [FIXED_WIDTH-1:0]  di;
        roll = $urandom_range(99);
        // default: a window around the set
        sr = FIXED_WIDTH'(int'($urandom_range(805306368)) - 671088640);
        si = FIXED_WIDTH'(int'($urandom_range(805306368)) - 402653184);
        dr = jitter(196608);
        di = jitter(196608);
        lim = $urandom_range(64, 1);
        items = $urandom_range(40, 20);
        if (roll < 45)
        begin
        end
        else if (roll < 60)
        begin
            lim = $urandom_range(300, 65);
        end
        else if (roll < 72)
        begin
            lim = 1000;
            items = $urandom_range(10, 6);
        end
        else if (roll < 84)
        begin
            sr = $urandom();
            dr = $urandom();
            si = $urandom();
            di = $urandom();
            lim = $urandom_range(32, 1);
        end
        else if (roll < 94)
        begin
            sr = pick_extreme();
            dr = pick_extreme();
            si = pick_extreme();
            di = pick_extreme();
            lim = $urandom_range(16, 1);
        end
        else
        begin
            lim = $urandom_range(1, 0);
        end
        settle();
        cfg_put(mbep_pkg::CFG_START_RE, sr);
        cfg_put(mbep_pkg::CFG_STEP_RE, dr);
        cfg_put(mbep_pkg::CFG_START_IM, si);
        cfg_put(mbep_pkg::CFG_STEP_IM, di);
        cfg_put(mbep_pkg::CFG_MAX_ITER, FIXED_WIDTH'(lim));
        cfg_put(CFG_IDX_BITS'($urandom_range(CFG_UNMAPPED_HI, CFG_UNMAPPED_LO)),
                $urandom());
        cfg_write_en <= 1'b0;
        calm = ($urandom_range(4) == 0);
    endtask

    initial
    begin
        int               items;
        int               sent;
        mbep_pkg::pixel_t px;

        plan = '{
            pix_row(0, 0),
            pix_row(4095, 4095),
            pix_row(12'hAAA, 12'h555),
            cfg_row(CFG_UNMAPPED_LO, '0),
            cfg_row(CFG_UNMAPPED_HI, FX_MAX),
            pix_row(0, 0),
            // c saturates far outside: one iteration
            cfg_row(mbep_pkg::CFG_START_RE, FX_MAX),
            cfg_row(mbep_pkg::CFG_STEP_RE, FX_MAX),
            cfg_row(mbep_pkg::CFG_START_IM, FX_MIN),
            cfg_row(mbep_pkg::CFG_STEP_IM, FX_MIN),
            chk_row(4095, 4095, 1, 1'b0, 29, 24, 4),
            chk_row(0, 0, 1, 1'b0, 29, 24, 4),
            cfg_row(mbep_pkg::CFG_MAX_ITER, 32'd2),
            chk_row(4095, 0, 1, 1'b0, 221, 213, 4),
            cfg_row(mbep_pkg::CFG_MAX_ITER, 32'd1),
            chk_row(0, 4095, 1, 1'b1, 0, 0, 0),
            cfg_row(mbep_pkg::CFG_MAX_ITER, 32'd0),
            chk_row(12'hAAA, 12'h555, 0, 1'b1, 0, 0, 0),
            cfg_row(mbep_pkg::CFG_MAX_ITER, 32'd65535),
            chk_row(12'h555, 12'hAAA, 1, 1'b0, 29, 24, 4),
            // c = 0 never escapes
            cfg_row(mbep_pkg::CFG_START_RE, '0),
            cfg_row(mbep_pkg::CFG_STEP_RE, '0),
            cfg_row(mbep_pkg::CFG_START_IM, '0),
            cfg_row(mbep_pkg::CFG_STEP_IM, '0),
            chk_row(4095, 4095, 65535, 1'b1, 0, 0, 0),
            cfg_row(mbep_pkg::CFG_MAX_ITER, 32'd1000),
            chk_row(7, 9, 1000, 1'b1, 0, 0, 0),
            cfg_row(mbep_pkg::CFG_START_RE, FX_NEG_TWO),
            cfg_row(mbep_pkg::CFG_STEP_RE, FX_PITCH),
            cfg_row(mbep_pkg::CFG_START_IM, FX_NEG_ONE_HALF),
            cfg_row(mbep_pkg::CFG_STEP_IM, FX_PITCH),
            cfg_row(mbep_pkg::CFG_MAX_ITER, 32'd256),
            pix_row(0, 0),
            pix_row(2048, 1024),
            pix_row(2048, 2750),
            pix_row(2048, 3100),
            pix_row(2600, 2400),
            pix_row(1400, 2300)
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                settle();
                cfg_put(plan[i].idx, plan[i].data);
                cfg_write_en <= 1'b0;
            end
            else
            begin
                send_pixel(plan[i].px, plan[i].typed ? plan[i].want : escape_pixel(plan[i].px));
                sender_gap();
            end
        end

        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            new_scene(items);
            for (int k = 0; k < items; k++)
            begin
                px.column = COORD_BITS'($urandom());
                px.row = COORD_BITS'($urandom());
                send_pixel(px, escape_pixel(px));
                sender_gap();
                if ($urandom_range(199) == 0)
                begin
                    settle();
                end
            end
            sent += items;
        end

        settle();
        repeat (64) @(posedge clk);

        $display("Checked %0d pixel transactions: %0d inside the set, %0d escaped.",
                 results_seen, inside_seen, results_seen - inside_seen);
        $display("%0d register writes over directed windows, extremes and random scenes.",
                 cfg_writes);
        if (errors == 0 && pixel_results_due.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("Timeout with %0d transactions outstanding", pixel_results_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
sv/mbep_pkg.sv
sv/mandelbrot_escape_pixel_core.sv
sim/tb.sv
